@@ src/stcp_pkg.sv @@
package stcp_pkg;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CASE_MASK = 8'hdf;

	localparam int WORDS    = 4;
	localparam int OUT_VALS = 6;

	localparam logic [5:0] COUNT_MAX = 6'h3f;

	localparam logic signed [15:0] YEAR_LOW  = 16'sd1970;
	localparam logic signed [15:0] YEAR_HIGH = 16'sd2099;

	localparam logic [2:0] CMD_HELP = 3'd0;
	localparam logic [2:0] CMD_TIME = 3'd1;
	localparam logic [2:0] CMD_QUIT = 3'd2;
	localparam logic [2:0] CMD_DATE = 3'd3;
	localparam logic [2:0] CMD_NONE = 3'd4;

	localparam logic [3:0] ST_UNKNOWN  = 4'd0;
	localparam logic [3:0] ST_HELP     = 4'd1;
	localparam logic [3:0] ST_TIME_ASK = 4'd2;
	localparam logic [3:0] ST_DATE_ASK = 4'd3;
	localparam logic [3:0] ST_TIME_SET = 4'd4;
	localparam logic [3:0] ST_DATE_SET = 4'd5;
	localparam logic [3:0] ST_QUIT     = 4'd6;
	localparam logic [3:0] ST_COUNT    = 4'd7;
	localparam logic [3:0] ST_BAD      = 4'd8;

	typedef logic [OUT_VALS-1:0][15:0] field_vals_t;

	typedef struct packed {
		logic time_ok;
		logic date_ok;
	} check_t;

	// command word text, upper case, indexed by word and character position
	function automatic logic [7:0] word_char(input logic [1:0] w, input logic [2:0] i);
		logic [7:0] c;
		c = 8'd0;
		unique case (w)
			2'd0: begin
				case (i)
					3'd0: c = "H";
					3'd1: c = "E";
					3'd2: c = "L";
					3'd3: c = "P";
					default: c = 8'd0;
				endcase
			end
			2'd1: begin
				case (i)
					3'd0: c = "S";
					3'd1: c = "E";
					3'd2: c = "T";
					3'd3: c = "T";
					3'd4: c = "I";
					3'd5: c = "M";
					3'd6: c = "E";
					default: c = 8'd0;
				endcase
			end
			2'd2: begin
				case (i)
					3'd0: c = "Q";
					3'd1: c = "U";
					3'd2: c = "I";
					3'd3: c = "T";
					default: c = 8'd0;
				endcase
			end
			default: begin
				case (i)
					3'd0: c = "S";
					3'd1: c = "E";
					3'd2: c = "T";
					3'd3: c = "D";
					3'd4: c = "A";
					3'd5: c = "T";
					3'd6: c = "E";
					default: c = 8'd0;
				endcase
			end
		endcase
		return c;
	endfunction

	function automatic logic [3:0] word_len(input logic [1:0] w);
		logic [3:0] n;
		n = 4'd4;
		unique case (w)
			2'd0: n = 4'd4;
			2'd1: n = 4'd7;
			2'd2: n = 4'd4;
			default: n = 4'd7;
		endcase
		return n;
	endfunction

endpackage

@@ src/stcp_field_check.sv @@
module stcp_field_check (
	input  stcp_pkg::field_vals_t vals,
	output stcp_pkg::check_t      chk
);
	import stcp_pkg::*;

	function automatic logic hms_ok(input logic signed [15:0] h,
			input logic signed [15:0] m, input logic signed [15:0] s);
		return (h >= 16'sd0) && (h < 16'sd24) && (m >= 16'sd0) && (m < 16'sd60) &&
			(s > 16'sd0) && (s <= 16'sd60);
	endfunction

	logic signed [15:0] y, mo, d;

	assign y  = $signed(vals[0]);
	assign mo = $signed(vals[1]);
	assign d  = $signed(vals[2]);

	assign chk.time_ok = hms_ok($signed(vals[0]), $signed(vals[1]), $signed(vals[2]));
	assign chk.date_ok = (y > YEAR_LOW) && (y < YEAR_HIGH) && (mo > 16'sd0) && (mo < 16'sd13) &&
		(d > 16'sd0) && (d < 16'sd32) &&
		hms_ok($signed(vals[3]), $signed(vals[4]), $signed(vals[5]));

endmodule

@@ src/serial_text_command_parser.sv @@
// res_valid is registered: the LF that ends its line, after a CR, is held in the input register,
// then the result of its line is loaded into the result register.
// Throughput: one byte per cycle. A full byte register stalls input only while a finished
// result sits in the result register and the receiver stalls it.
// Reset clears framing, matching, parsing and wait state; the field store is not cleared.
module serial_text_command_parser #(
	parameter int LINE_LIMIT  = 64,
	parameter int FIELD_SLOTS = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_stall,
	input  logic [7:0]         rx_byte,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [3:0]         status,
	output logic [2:0]         command,
	output logic [5:0]         field_count,
	output logic signed [15:0] value_a,
	output logic signed [15:0] value_b,
	output logic signed [15:0] value_c,
	output logic signed [15:0] value_d,
	output logic signed [15:0] value_e,
	output logic signed [15:0] value_f
);
	import stcp_pkg::*;

	localparam int LEN_W = $clog2(LINE_LIMIT);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       go;

	// line state
	logic             cr_q;
	logic [LEN_W-1:0] len_q;
	logic             wait_q;
	logic [2:0]       active_q;
	logic [WORDS-1:0] match_q;
	logic [15:0]      acc_q;
	logic [5:0]       fields_q;
	logic             prev_sp_q;
	logic [15:0]      store_q [FIELD_SLOTS];

	// result register
	logic              out_valid_q;
	logic [3:0]        status_q;
	logic [2:0]        command_q;
	logic [5:0]        count_q;
	field_vals_t       vals_q;

	assign go       = valid_s1 && !(out_valid_q && res_stall);
	assign rx_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// byte decode
	logic             is_lf, is_cr, is_sp, letter;
	logic [7:0]       folded;
	logic [WORDS-1:0] match_nx;
	logic [15:0]      acc_nx;
	logic             close_w;
	logic [LEN_W:0]   len_inc;
	logic             overflow;
	logic [5:0]       fields_inc;

	assign is_lf  = byte_s1 == CH_LF;
	assign is_cr  = byte_s1 == CH_CR;
	assign is_sp  = byte_s1 == CH_SPACE;
	assign letter = ((byte_s1 >= 8'd65) && (byte_s1 <= 8'd90)) ||
		((byte_s1 >= 8'd97) && (byte_s1 <= 8'd122));
	assign folded = byte_s1 & CASE_MASK;

	always_comb begin
		for (int t = 0; t < WORDS; t++) begin
			match_nx[t] = match_q[t] && letter &&
				({{(LEN_W > 4 ? LEN_W - 4 : 0){1'b0}}, word_len(2'(t))} > (LEN_W)'(len_q)) &&
				(folded == word_char(2'(t), len_q[2:0]));
		end
	end

	assign acc_nx     = 16'((acc_q << 3) + (acc_q << 1) + {8'd0, byte_s1} - {8'd0, CH_ZERO});
	assign close_w    = is_sp && !prev_sp_q;
	assign len_inc    = {1'b0, len_q} + (LEN_W+1)'(1);
	assign overflow   = len_inc >= (LEN_W+1)'(LINE_LIMIT);
	assign fields_inc = (fields_q == COUNT_MAX) ? fields_q : fields_q + 6'd1;

	// line end evaluation
	logic             line_nonempty;
	logic [5:0]       fields_fin;
	logic [WORDS-1:0] hit;
	logic             wait_eff;
	field_vals_t      vals_fin;
	check_t           chk;
	logic [3:0]       st_fin;
	logic [2:0]       cmd_fin;
	logic [5:0]       cnt_fin;
	field_vals_t      out_vals;
	logic             wait_fin;
	logic [2:0]       active_fin;

	assign line_nonempty = len_q != '0;
	assign fields_fin    = line_nonempty ? fields_inc : fields_q;

	always_comb begin
		for (int t = 0; t < WORDS; t++) begin
			hit[t] = match_q[t] && ((LEN_W)'(len_q) ==
				(LEN_W)'({{(LEN_W > 4 ? LEN_W - 4 : 0){1'b0}}, word_len(2'(t))}));
		end
	end

	assign wait_eff = wait_q && !hit[CMD_QUIT[1:0]];

	// the last field is still in the accumulator at line end
	always_comb begin
		for (int j = 0; j < OUT_VALS; j++) begin
			if (6'(j) >= fields_fin) begin
				vals_fin[j] = 16'd0;
			end else if (line_nonempty && fields_q == 6'(j)) begin
				vals_fin[j] = acc_q;
			end else begin
				vals_fin[j] = store_q[j];
			end
		end
	end

	stcp_field_check u_check (
		.vals (vals_fin),
		.chk  (chk)
	);

	always_comb begin
		st_fin     = ST_UNKNOWN;
		cmd_fin    = CMD_NONE;
		cnt_fin    = 6'd0;
		out_vals   = '0;
		wait_fin   = wait_eff;
		active_fin = active_q;
		if (!wait_eff) begin
			if (hit[0]) begin
				st_fin     = ST_HELP;
				cmd_fin    = CMD_HELP;
				active_fin = CMD_NONE;
			end else if (hit[1]) begin
				st_fin     = ST_TIME_ASK;
				cmd_fin    = CMD_TIME;
				wait_fin   = 1'b1;
				active_fin = CMD_TIME;
			end else if (hit[2]) begin
				st_fin     = ST_QUIT;
				cmd_fin    = CMD_QUIT;
				active_fin = CMD_NONE;
			end else if (hit[3]) begin
				st_fin     = ST_DATE_ASK;
				cmd_fin    = CMD_DATE;
				wait_fin   = 1'b1;
				active_fin = CMD_DATE;
			end
		end else if (active_q != CMD_TIME && active_q != CMD_DATE) begin
			wait_fin   = 1'b0;
			active_fin = CMD_NONE;
		end else begin
			cmd_fin  = active_q;
			cnt_fin  = fields_fin;
			out_vals = vals_fin;
			if (active_q == CMD_TIME) begin
				if (fields_fin != 6'd3) begin
					st_fin = ST_COUNT;
				end else if (!chk.time_ok) begin
					st_fin = ST_BAD;
				end else begin
					st_fin = ST_TIME_SET;
				end
			end else begin
				if (fields_fin != 6'd6) begin
					st_fin = ST_COUNT;
				end else if (!chk.date_ok) begin
					st_fin = ST_BAD;
				end else begin
					st_fin = ST_DATE_SET;
				end
			end
			if (st_fin == ST_TIME_SET || st_fin == ST_DATE_SET) begin
				wait_fin   = 1'b0;
				active_fin = CMD_NONE;
			end
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_q      <= 1'b0;
			len_q     <= '0;
			wait_q    <= 1'b0;
			active_q  <= CMD_NONE;
			match_q   <= '1;
			acc_q     <= 16'd0;
			fields_q  <= 6'd0;
			prev_sp_q <= 1'b1;
		end else if (go) begin
			if (cr_q || (!is_cr && overflow)) begin
				// restart the line
				cr_q      <= 1'b0;
				len_q     <= '0;
				match_q   <= '1;
				acc_q     <= 16'd0;
				fields_q  <= 6'd0;
				prev_sp_q <= 1'b1;
				if (cr_q && is_lf) begin
					wait_q   <= wait_fin;
					active_q <= active_fin;
				end
			end else if (is_cr) begin
				cr_q <= 1'b1;
			end else begin
				len_q     <= len_inc[LEN_W-1:0];
				match_q   <= match_nx;
				prev_sp_q <= is_sp;
				if (!is_sp) begin
					acc_q <= acc_nx;
				end else if (close_w) begin
					acc_q    <= 16'd0;
					fields_q <= fields_inc;
				end
			end
		end
	end

	// fields past the store are counted but dropped
	always_ff @(posedge clk) begin
		if (go && !cr_q && !is_cr && close_w) begin
			for (int j = 0; j < FIELD_SLOTS; j++) begin
				if (fields_q == 6'(j)) begin
					store_q[j] <= acc_q;
				end
			end
		end
	end

	// result register
	logic emit;

	assign emit = go && cr_q && is_lf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q  <= st_fin;
			command_q <= cmd_fin;
			count_q   <= cnt_fin;
			vals_q    <= out_vals;
		end
	end

	assign res_valid   = out_valid_q;
	assign status      = status_q;
	assign command     = command_q;
	assign field_count = count_q;
	assign value_a     = $signed(vals_q[0]);
	assign value_b     = $signed(vals_q[1]);
	assign value_c     = $signed(vals_q[2]);
	assign value_d     = $signed(vals_q[3]);
	assign value_e     = $signed(vals_q[4]);
	assign value_f     = $signed(vals_q[5]);

endmodule
